/* rtl/lkv_pkg.sv */
// shared types and constants of the lru key/value cache
package lkv_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  localparam logic signed [VAL_W-1:0] READ_MISS = '1;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef struct packed {
    logic lookup;  // capture compare result of the presented key
    logic shift;   // load key, value and valid from the upstream neighbor
  } cell_ctl_t;

endpackage

/* rtl/lkv_cell.sv */
// one position of the recency stack: key, value, valid and a match flag
module lkv_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lkv_pkg::cell_ctl_t                     ctl_i,
  input  logic signed [lkv_pkg::KEY_W-1:0]       cmp_key_i,
  input  logic signed [lkv_pkg::KEY_W-1:0]       up_key_i,
  input  logic signed [lkv_pkg::VAL_W-1:0]       up_val_i,
  input  logic                                   up_valid_i,
  output logic signed [lkv_pkg::KEY_W-1:0]       key_o,
  output logic signed [lkv_pkg::VAL_W-1:0]       val_o,
  output logic                                   valid_o,
  output logic                                   match_o
);

  logic signed [lkv_pkg::KEY_W-1:0] key_q;
  logic signed [lkv_pkg::VAL_W-1:0] val_q;
  logic                             valid_q, valid_d;
  logic                             match_q, match_d;

  always_comb begin
    valid_d = ctl_i.shift ? up_valid_i : valid_q;
    match_d = ctl_i.lookup ? (valid_q && (key_q == cmp_key_i)) : match_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      key_q <= up_key_i;
      val_q <= up_val_i;
    end
  end

  assign key_o   = key_q;
  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

/* rtl/lru_key_value_cache_core.sv */
// top level of the lru key/value cache: cell chain, sequencer and output register
// result path: a get is compared on its input transfer and its result is loaded into the output
//   register at the end of its shift cycle, which waits while an earlier result is not taken
// input: a new item is taken only after the compare cycle and the shift cycle of the last one
//   in the cell chain; a pending result that is not taken holds the next get in its shift cycle
// reset: rst_ni asynchronous active low empties the stack, clears occupancy and sets
//   capacity to 16; no clearing pass, the block is ready right after reset
module lru_key_value_cache_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]              cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   in_mode_i,
  input  logic signed [lkv_pkg::KEY_W-1:0]       in_key_i,
  input  logic signed [lkv_pkg::VAL_W-1:0]       in_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   out_hit_o,
  output logic signed [lkv_pkg::VAL_W-1:0]       out_read_value_o
);

  localparam int unsigned D = lkv_pkg::DEPTH;

  typedef enum logic {ST_IDLE, ST_UPDATE} state_e;

  state_e                              state_q;
  logic                                op_mode_q;
  logic signed [lkv_pkg::KEY_W-1:0]    op_key_q;
  logic signed [lkv_pkg::VAL_W-1:0]    op_val_q;
  logic [lkv_pkg::CAP_W-1:0]           cap_q;
  logic [lkv_pkg::OCC_W-1:0]           occ_q;
  logic                                out_valid_q, out_hit_q;
  logic signed [lkv_pkg::VAL_W-1:0]    out_val_q;

  logic signed [lkv_pkg::KEY_W-1:0]    cell_key [D];
  logic signed [lkv_pkg::VAL_W-1:0]    cell_val [D];
  logic [D-1:0]                        cell_valid;
  logic [D-1:0]                        cell_match;
  logic [D-1:0]                        shift_en;

  logic                                in_fire, upd_fire, res_load, hit_any, room;
  logic signed [lkv_pkg::VAL_W-1:0]    hit_val;
  logic signed [lkv_pkg::VAL_W-1:0]    top_val;
  logic [lkv_pkg::OCC_W-1:0]           eff_cap;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // a get waits in its shift cycle until the output register is free
  assign upd_fire   = (state_q == ST_UPDATE) &&
                      ((op_mode_q == lkv_pkg::MODE_SET) || !out_valid_q || out_ready_i);
  assign res_load   = upd_fire && (op_mode_q == lkv_pkg::MODE_GET);

  assign hit_any = |cell_match;

  always_comb begin
    hit_val = '0;
    for (int unsigned i = 0; i < D; i++) begin
      hit_val = hit_val | (cell_match[i] ? cell_val[i] : '0);
    end
  end

  // capacity clamped to 1 .. DEPTH
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lkv_pkg::OCC_W'(1);
    end else if (32'(cap_q) > D) begin
      eff_cap = lkv_pkg::OCC_W'(D);
    end else begin
      eff_cap = lkv_pkg::OCC_W'(cap_q);
    end
  end

  assign room    = occ_q < eff_cap;
  assign top_val = (op_mode_q == lkv_pkg::MODE_SET) ? op_val_q : hit_val;

  // shift window: positions up to the hit, up to occupancy on insert, up to the bottom on evict, none on a miss
  for (genvar i = 0; i < D; i++) begin : g_shift
    logic [D-1:0] below;
    logic         win;
    assign below = cell_match >> i;
    if (i == 0) begin : g_top
      always_comb begin
        if (hit_any) begin
          win = |below;
        end else if (op_mode_q == lkv_pkg::MODE_SET) begin
          win = room ? 1'b1 : cell_valid[i];
        end else begin
          win = 1'b0;
        end
      end
    end else begin : g_rest
      always_comb begin
        if (hit_any) begin
          win = |below;
        end else if (op_mode_q == lkv_pkg::MODE_SET) begin
          win = room ? cell_valid[i-1] : cell_valid[i];
        end else begin
          win = 1'b0;
        end
      end
    end
    assign shift_en[i] = upd_fire && win;
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    lkv_pkg::cell_ctl_t                ctl;
    logic signed [lkv_pkg::KEY_W-1:0]  up_key;
    logic signed [lkv_pkg::VAL_W-1:0]  up_val;
    logic                              up_valid;
    assign ctl.lookup = in_fire;
    assign ctl.shift  = shift_en[i];
    if (i == 0) begin : g_head
      assign up_key   = op_key_q;
      assign up_val   = top_val;
      assign up_valid = 1'b1;
    end else begin : g_link
      assign up_key   = cell_key[i-1];
      assign up_val   = cell_val[i-1];
      assign up_valid = cell_valid[i-1];
    end
    lkv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cmp_key_i  (in_key_i),
      .up_key_i   (up_key),
      .up_val_i   (up_val),
      .up_valid_i (up_valid),
      .key_o      (cell_key[i]),
      .val_o      (cell_val[i]),
      .valid_o    (cell_valid[i]),
      .match_o    (cell_match[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_mode_q   <= lkv_pkg::MODE_GET;
      op_key_q    <= '0;
      op_val_q    <= '0;
      cap_q       <= lkv_pkg::CAP_W'(16);
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_val_q   <= lkv_pkg::READ_MISS;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
        out_hit_q   <= hit_any;
        out_val_q   <= hit_any ? hit_val : lkv_pkg::READ_MISS;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_mode_q <= in_mode_i;
            op_key_q  <= in_key_i;
            op_val_q  <= in_value_i;
            state_q   <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (upd_fire) begin
            state_q <= ST_IDLE;
            if ((op_mode_q == lkv_pkg::MODE_SET) && !hit_any && room) begin
              occ_q <= occ_q + lkv_pkg::OCC_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;
  assign out_read_value_o = out_val_q;

endmodule

/* rtl/lkv_checker.sv */
// port-level checks of the lru key/value cache, bound to the top level
module lkv_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   cfg_we_i,
  input logic [lkv_pkg::CAP_W-1:0]              cfg_wdata_i,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   in_mode_i,
  input logic signed [lkv_pkg::KEY_W-1:0]       in_key_i,
  input logic signed [lkv_pkg::VAL_W-1:0]       in_value_i,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic                                   out_hit_o,
  input logic signed [lkv_pkg::VAL_W-1:0]       out_read_value_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_hit_o) &&
    $stable(out_read_value_o))
    else $error("result changed while stalled");

  // a miss always reads back all ones
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_hit_o |-> out_read_value_o == lkv_pkg::READ_MISS)
    else $error("miss without all-ones value");

  // after an input transfer the block is busy for its shift cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken in back-to-back cycles");

  // a new result only comes out of a shift cycle
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an update cycle");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_we_i         (cfg_we_i),
  .cfg_wdata_i      (cfg_wdata_i),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .in_mode_i        (in_mode_i),
  .in_key_i         (in_key_i),
  .in_value_i       (in_value_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_hit_o        (out_hit_o),
  .out_read_value_o (out_read_value_o)
);

/* dv/lru_key_value_cache_core_test.sv */
// self-checking testbench of the lru key/value cache core with its own recency-stack predictor
module lru_key_value_cache_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } lookup_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_mode = MODE_GET;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_ready = 1'b0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic                    out_hit_o;
  logic signed [VAL_W-1:0] out_read_value_o;

  lru_key_value_cache_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .in_mode_i        (in_mode),
    .in_key_i         (in_key),
    .in_value_i       (in_value),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .out_hit_o        (out_hit_o),
    .out_read_value_o (out_read_value_o)
  );

  // recency stack of the predictor, slot 0 is the most recent entry
  logic signed [KEY_W-1:0] stack_key [DEPTH];
  logic signed [VAL_W-1:0] stack_val [DEPTH];
  int unsigned             stack_fill = 0;
  logic [CAP_W-1:0]        cap_reg = CAP_W'(16);

  lookup_result_t          pending_lookups [$];

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 57;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned n_hits = 0;
  int unsigned n_misses = 0;
  int unsigned n_updates = 0;
  int unsigned n_inserts = 0;
  int unsigned n_evictions = 0;
  int unsigned n_cap_writes = 0;
  int unsigned idle_cycles = 0;

  logic signed [KEY_W-1:0] key_pool [$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int find_slot(logic signed [KEY_W-1:0] key);
    for (int i = 0; i < int'(stack_fill); i++) begin
      if (stack_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void move_to_top(int pos, logic signed [KEY_W-1:0] key,
                                      logic signed [VAL_W-1:0] val);
    for (int i = pos; i > 0; i--) begin
      stack_key[i] = stack_key[i-1];
      stack_val[i] = stack_val[i-1];
    end
    stack_key[0] = key;
    stack_val[0] = val;
  endfunction

  function automatic void apply_transfer(logic mode, logic signed [KEY_W-1:0] key,
                                         logic signed [VAL_W-1:0] val);
    int                      pos;
    int unsigned             eff_cap;
    logic signed [VAL_W-1:0] got;
    pos = find_slot(key);
    if (mode == MODE_GET) begin
      if (pos >= 0) begin
        got = stack_val[pos];
        pending_lookups.push_back('{hit: 1'b1, read_value: got});
        move_to_top(pos, key, got);
        n_hits++;
      end else begin
        pending_lookups.push_back('{hit: 1'b0, read_value: READ_MISS});
        n_misses++;
      end
    end else if (pos >= 0) begin
      move_to_top(pos, key, val);
      n_updates++;
    end else begin
      // zero means one, anything above the stack depth saturates
      eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
      n_inserts++;
      if (stack_fill >= eff_cap) begin
        // only the bottom entry goes, even when capacity was lowered below the fill
        move_to_top(int'(stack_fill) - 1, key, val);
        n_evictions++;
      end else begin
        move_to_top(int'(stack_fill), key, val);
        stack_fill++;
      end
    end
  endfunction

  // input transfers and register writes feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_valid && in_ready_o) apply_transfer(in_mode, in_key, in_value);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: hit %0b value %0d", out_hit_o, out_read_value_o);
      end else begin
        want = pending_lookups.pop_front();
        if (out_hit_o !== want.hit || out_read_value_o !== want.read_value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected hit %0b value %0d, got hit %0b value %0d",
                     want.hit, want.read_value, out_hit_o, out_read_value_o);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_item(logic mode, logic signed [KEY_W-1:0] key,
                           logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    in_value <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid, let the predictor see the last transfer, wait for all lookups to return,
  // then let a trailing set finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    n_cap_writes++;
  endtask

  task automatic test_basic_get_set();
    send_item(MODE_GET, '0, $urandom());            // lookup on the empty store
    send_item(MODE_SET, KEY_MIN, VAL_MAX);
    send_item(MODE_SET, KEY_MAX, VAL_MIN);
    send_item(MODE_GET, KEY_MIN, '0);
    send_item(MODE_GET, KEY_MAX, '1);
    send_item(MODE_SET, KEY_MIN, '1);               // update of an existing key
    send_item(MODE_GET, KEY_MIN, $urandom());
    send_item(MODE_GET, '1, $urandom());
    send_item(MODE_SET, '0, '0);
    send_item(MODE_GET, '0, '1);
  endtask

  task automatic test_capacity_limits();
    // zero acts as one, and the fill of three stays above it
    write_capacity(CAP_W'(0));
    send_item(MODE_SET, 32'sd5, 32'sd55);
    send_item(MODE_GET, 32'sd5, '0);
    send_item(MODE_SET, 32'sd6, 32'sd66);
    send_item(MODE_GET, 32'sd5, '0);
    send_item(MODE_GET, KEY_MIN, '0);
    // above the stack depth saturates
    write_capacity('1);
    send_item(MODE_SET, 32'sd7, VAL_MIN);
    send_item(MODE_GET, 32'sd7, '0);
    send_item(MODE_GET, '0, '0);
    write_capacity(CAP_W'(2));
    send_item(MODE_SET, 32'sd8, 32'sd88);
    send_item(MODE_GET, 32'sd6, '0);
    send_item(MODE_GET, 32'sd8, '0);
  endtask

  task automatic random_phase(logic [CAP_W-1:0] cap, int unsigned n_items);
    int unsigned             eff_cap;
    int unsigned             pool_n;
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] val;
    write_capacity(cap);
    eff_cap = (cap == 0) ? 1 : ((cap > DEPTH) ? DEPTH : cap);
    pool_n  = eff_cap + $urandom_range(1, 6);
    key_pool.delete();
    key_pool.push_back(KEY_MIN);
    key_pool.push_back(KEY_MAX);
    while (key_pool.size() < pool_n) key_pool.push_back($urandom());
    for (int unsigned n = 0; n < n_items; n++) begin
      mode = 1'($urandom_range(1));
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_n - 1)];
      else key = $urandom();
      case ($urandom_range(9))
        0: val = VAL_MIN;
        1: val = VAL_MAX;
        2: val = '1;
        default: val = $urandom();
      endcase
      send_item(mode, key, val);
    end
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [9] = '{CAP_W'(16), CAP_W'(1), CAP_W'(5), '1, CAP_W'(0),
                                   CAP_W'(9), CAP_W'(2), CAP_W'(16), CAP_W'(0)};
    caps[8] = CAP_W'($urandom());
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 57;
      end else if (p < 6) begin
        send_idle_pct = 57;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(caps[p], 70);
    end
  endtask

  // receiver stalls for a long stretch while the sender keeps offering lookups and sets
  task automatic test_backpressure();
    logic signed [KEY_W-1:0] key;
    write_capacity(CAP_W'(8));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 8; i++) send_item(MODE_SET, 32'(i), $urandom());
    hold_left = 300;
    for (int i = 0; i < 50; i++) begin
      key = $urandom_range(11);
      send_item(($urandom_range(3) == 0) ? MODE_SET : MODE_GET, key, $urandom());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_get_set();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    // lookups that never came back count against the run
    while (pending_lookups.size() != 0) begin
      void'(pending_lookups.pop_front());
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("missing result: a lookup transfer produced no result");
    end
    $display("covered %0d hits, %0d misses, %0d updates, %0d inserts, %0d evictions",
             n_hits, n_misses, n_updates, n_inserts, n_evictions);
    $display("over %0d capacity writes with random stalls and one long output hold-off",
             n_cap_writes);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
